[rtl/websocket_frame_decoder_defines.svh]
// assertion macros for the websocket frame decoder
// included by the rtl modules that carry concurrent checks
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define WSFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsfd check failed");
// condition must never be seen at a clock edge out of reset
`define WSFD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("wsfd forbidden condition");
`else
`define WSFD_ASSERT(lbl, clk, rst_n, prop)
`define WSFD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/wsfd_pkg.sv]
// shared types and constants of the websocket frame decoder
// no dependencies
`timescale 1ns / 1ps

package wsfd_pkg;

    // header parse phases
    typedef enum logic [2:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_LEN16,
        PH_LEN64,
        PH_MASK,
        PH_DATA
    } t_phase;

    // result kinds
    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_EMPTY  = 3'd1,
        KIND_CLOSE  = 3'd2,
        KIND_RSV    = 3'd3,
        KIND_NOMASK = 3'd4,
        KIND_LONG   = 3'd5
    } t_kind;

    // opcodes
    localparam logic [3:0] OP_CONT          = 4'h0;
    localparam logic [3:0] OP_TEXT          = 4'h1;
    localparam logic [3:0] OP_BINARY        = 4'h2;
    localparam logic [3:0] OP_FIRST_CONTROL = 4'h3;
    localparam logic [3:0] OP_CLOSE         = 4'h8;

    // short length codes for extended length forms
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [31:0] MAX_LONG_RESET = 32'd262144;

    // one queued result: back end xors data with key
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
    } t_item;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/wsfd_front.sv]
// front end: frame header parser, length and mask tracking, result classification
// depends on wsfd_pkg and websocket_frame_decoder_defines.svh
`timescale 1ns / 1ps
`include "websocket_frame_decoder_defines.svh"

module wsfd_front import wsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    output logic        o_ready,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_item       o_item
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_final, n_final;
    logic [2:0]  r_rsv, n_rsv;
    logic [31:0] r_rem, n_rem;
    logic        r_rem_hi, n_rem_hi;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_pos, n_pos;
    logic        r_in_msg, n_in_msg;
    logic        r_given, n_given;
    logic        r_halted, n_halted;
    logic [31:0] r_max;

    logic        w_accept;
    logic        w_live;
    logic [31:0] w_rem_shift;
    logic        w_hi_next;
    logic        w_too_long;
    logic        w_last;
    logic        w_opens;
    logic        w_deliver;
    logic        w_mask_in_msg;
    logic        w_mask_given;
    logic        w_head1_fail;
    logic [7:0]  w_key_byte;

    // room for one result is enough for any item
    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign w_live   = w_accept && !r_halted;

    // shared header arithmetic
    assign w_rem_shift  = {r_rem[23:0], i_byte};
    assign w_hi_next    = r_rem_hi || (r_rem[31:24] != 8'd0);
    assign w_too_long   = w_hi_next || (w_rem_shift > r_max);
    assign w_last       = (r_rem == 32'd1);
    assign w_opens      = (r_opcode == OP_TEXT) || (r_opcode == OP_BINARY);
    assign w_deliver    = (r_opcode < OP_FIRST_CONTROL) && r_in_msg;
    assign w_head1_fail = (r_opcode == OP_CLOSE) || (r_rsv != 3'd0) || !i_byte[7];
    assign w_mask_in_msg = w_opens ? 1'b1 : r_in_msg;
    assign w_mask_given  = w_opens ? 1'b0 : r_given;

    // key byte for the current payload position, first key byte first
    always_comb begin
        case (r_pos)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // next parse phase
    always_comb begin
        n_phase = r_phase;
        if (w_live) begin
            case (r_phase)
                PH_HEAD0: n_phase = PH_HEAD1;
                PH_HEAD1: begin
                    if (!w_head1_fail) begin
                        if (i_byte[6:0] == LEN_EXT16) begin
                            n_phase = PH_LEN16;
                        end else if (i_byte[6:0] == LEN_EXT64) begin
                            n_phase = PH_LEN64;
                        end else begin
                            n_phase = PH_MASK;
                        end
                    end
                end
                PH_LEN16: begin
                    if (r_cnt == 3'd1) begin
                        n_phase = PH_MASK;
                    end
                end
                PH_LEN64: begin
                    if (r_cnt == 3'd7 && !w_too_long) begin
                        n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    if (r_cnt == 3'd3) begin
                        n_phase = (r_rem != 32'd0) ? PH_DATA : PH_HEAD0;
                    end
                end
                PH_DATA: begin
                    if (w_last) begin
                        n_phase = PH_HEAD0;
                    end
                end
                default: n_phase = PH_HEAD0;
            endcase
        end
    end

    // header fields, counters, message tracking and the result for this item
    always_comb begin
        n_cnt    = r_cnt;
        n_opcode = r_opcode;
        n_final  = r_final;
        n_rsv    = r_rsv;
        n_rem    = r_rem;
        n_rem_hi = r_rem_hi;
        n_key    = r_key;
        n_pos    = r_pos;
        n_in_msg = r_in_msg;
        n_given  = r_given;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_item   = '{kind: KIND_BYTE, data: 8'd0, key: 8'd0, last: 1'b0};
        if (w_live) begin
            case (r_phase)
                PH_HEAD0: begin
                    n_opcode = i_byte[3:0];
                    n_final  = i_byte[7];
                    n_rsv    = i_byte[6:4];
                    n_cnt    = 3'd0;
                end
                PH_HEAD1: begin
                    if (w_head1_fail) begin
                        n_halted = 1'b1;
                        o_push   = 1'b1;
                        if (r_opcode == OP_CLOSE) begin
                            o_item.kind = KIND_CLOSE;
                        end else if (r_rsv != 3'd0) begin
                            o_item.kind = KIND_RSV;
                        end else begin
                            o_item.kind = KIND_NOMASK;
                        end
                    end else begin
                        n_cnt    = 3'd0;
                        n_rem_hi = 1'b0;
                        if (i_byte[6:0] == LEN_EXT16 || i_byte[6:0] == LEN_EXT64) begin
                            n_rem = 32'd0;
                        end else begin
                            n_rem = {25'd0, i_byte[6:0]};
                        end
                    end
                end
                PH_LEN16: begin
                    n_rem = w_rem_shift;
                    n_cnt = (r_cnt == 3'd1) ? 3'd0 : r_cnt + 3'd1;
                end
                PH_LEN64: begin
                    n_rem    = w_rem_shift;
                    n_rem_hi = w_hi_next;
                    n_cnt    = r_cnt + 3'd1;
                    if (r_cnt == 3'd7 && w_too_long) begin
                        n_halted    = 1'b1;
                        o_push      = 1'b1;
                        o_item.kind = KIND_LONG;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        n_cnt    = 3'd0;
                        n_pos    = 2'd0;
                        n_in_msg = w_mask_in_msg;
                        n_given  = w_mask_given;
                        // empty frame: may close the message
                        if (r_rem == 32'd0 && r_final && w_mask_in_msg
                                && (r_opcode < OP_FIRST_CONTROL)) begin
                            n_in_msg = 1'b0;
                            n_given  = 1'b0;
                            if (w_mask_given) begin
                                o_push      = 1'b1;
                                o_item.kind = KIND_EMPTY;
                                o_item.last = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    n_rem = r_rem - 32'd1;
                    n_pos = r_pos + 2'd1;
                    if (w_deliver) begin
                        n_given     = 1'b1;
                        o_push      = 1'b1;
                        o_item.data = i_byte;
                        o_item.key  = w_key_byte;
                        if (w_last && r_final) begin
                            n_in_msg    = 1'b0;
                            n_given     = 1'b0;
                            o_item.last = 1'b1;
                        end
                    end
                end
                default: n_cnt = 3'd0;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD0;
            r_cnt    <= 3'd0;
            r_opcode <= 4'd0;
            r_final  <= 1'b0;
            r_rsv    <= 3'd0;
            r_rem    <= 32'd0;
            r_rem_hi <= 1'b0;
            r_key    <= 32'd0;
            r_pos    <= 2'd0;
            r_in_msg <= 1'b0;
            r_given  <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_opcode <= n_opcode;
            r_final  <= n_final;
            r_rsv    <= n_rsv;
            r_rem    <= n_rem;
            r_rem_hi <= n_rem_hi;
            r_key    <= n_key;
            r_pos    <= n_pos;
            r_in_msg <= n_in_msg;
            r_given  <= n_given;
            r_halted <= n_halted;
        end
    end

    // length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LONG_RESET;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    `WSFD_ASSERT(a_halt_quiet, i_clk, i_rst_n, r_halted |-> !o_push)
    `WSFD_NEVER(a_data_len, i_clk, i_rst_n, r_phase == PH_DATA && r_rem == 32'd0)

endmodule

[rtl/wsfd_queue.sv]
// short result queue between the header front end and the output back end
// depends on wsfd_pkg and websocket_frame_decoder_defines.svh
`timescale 1ns / 1ps
`include "websocket_frame_decoder_defines.svh"

module wsfd_queue import wsfd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    // pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `WSFD_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_stat.full)
    `WSFD_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_stat.empty)

endmodule

[rtl/wsfd_back.sv]
// back end: unmasks queued results into the output register
// depends on wsfd_pkg and websocket_frame_decoder_defines.svh
`timescale 1ns / 1ps
`include "websocket_frame_decoder_defines.svh"

module wsfd_back import wsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic [2:0] o_kind,
    output logic       o_last
);

    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_data;
    logic       r_last;

    // load when the output register is free or being taken
    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // unmasked payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_item.kind;
            r_data <= i_item.data ^ i_item.key;
            r_last <= i_item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    `WSFD_NEVER(a_last_kind, i_clk, i_rst_n,
        r_valid && r_last && r_kind != KIND_BYTE && r_kind != KIND_EMPTY)

endmodule

[rtl/websocket_frame_decoder.sv]
// websocket frame decoder, client-to-server direction
// depends on wsfd_pkg, wsfd_front, wsfd_queue, wsfd_back
`timescale 1ns / 1ps
//
// usage:
// - s_axis carries one received byte per item in tdata; m_axis gives
//   results: tdata is the unmasked payload byte (zero for non-payload kinds),
//   tuser the result kind, tlast marks the end of a message
// - i_cfg_wr_en / i_cfg_wr_data set the largest payload length allowed in the
//   64-bit length form; write it only while the block is idle
// - throughput is one byte per cycle while the result queue is not full;
//   header parsing, length tracking and unmask key selection all finish
//   in the cycle the byte is accepted
// - the front end writes the classified result into the queue at the
//   accepting edge; the back end then unmasks it into the output register
// - when the receiver stalls, the output register and the result queue
//   absorb results; s_axis_tready drops only once the queue is full
// - after close or a protocol error the block reports once, then accepts
//   and drops every byte until reset
// - reset is synchronous; no clearing pass, the block is ready the cycle
//   after reset is released

module websocket_frame_decoder import wsfd_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // message_last
);

    logic    w_push;
    logic    w_pop;
    t_item   w_front_item;
    t_item   w_queue_item;
    t_q_stat w_q_stat;

    // header parser and classifier
    wsfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .o_ready       (s_axis_tready),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    // decoupling queue
    wsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_q_stat)
    );

    // unmask and output register
    wsfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_queue_item),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_kind   (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

endmodule

[tb/wsfd_result_checker.sv]
// result checker for the websocket frame decoder: decodes every accepted byte on its own
// and compares each result item on the output stream with the oldest decoded result
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_result_checker import wsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [7:0] payload_byte
    input  logic [2:0]  i_m_tuser,    // [2:0] kind
    input  logic        i_m_tlast,    // message_last
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_decoded;

    // results decoded but not yet seen on the output
    t_decoded decoded_q[$];

    // own copy of the decoder state
    logic [31:0] max_long_len;
    t_phase      phase;
    logic [3:0]  hdr_cnt;
    logic [3:0]  opcode;
    logic        fin;
    logic [2:0]  rsv;
    logic [6:0]  short_len;
    logic [63:0] remaining;
    logic [31:0] mask_key;
    logic [1:0]  mask_pos;
    logic        msg_open;
    logic        msg_has_bytes;
    logic        stopped;
    int          fails;

    task automatic push_result(input t_kind kind, input logic [7:0] data, input logic last);
        t_decoded res;
        res.kind = kind;
        res.data = data;
        res.last = last;
        decoded_q.push_back(res);
    endtask

    // close and protocol errors report once and freeze the decoder
    task automatic stop_with(input t_kind kind);
        stopped = 1'b1;
        push_result(kind, 8'h00, 1'b0);
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        logic [7:0] plain;
        logic       frame_done;
        if (!stopped) begin
            case (phase)
                PH_HEAD1: begin
                    if (opcode == OP_CLOSE) begin
                        stop_with(KIND_CLOSE);
                    end else if (rsv != 3'd0) begin
                        stop_with(KIND_RSV);
                    end else if (!b[7]) begin
                        stop_with(KIND_NOMASK);
                    end else begin
                        short_len = b[6:0];
                        hdr_cnt   = 4'd0;
                        if (short_len == LEN_EXT16) begin
                            remaining = 64'd0;
                            phase     = PH_LEN16;
                        end else if (short_len == LEN_EXT64) begin
                            remaining = 64'd0;
                            phase     = PH_LEN64;
                        end else begin
                            remaining = {57'd0, short_len};
                            phase     = PH_MASK;
                        end
                    end
                end
                PH_LEN16, PH_LEN64: begin
                    remaining = {remaining[55:0], b};
                    hdr_cnt   = hdr_cnt + 4'd1;
                    if (phase == PH_LEN16 && hdr_cnt == 4'd2) begin
                        hdr_cnt = 4'd0;
                        phase   = PH_MASK;
                    end else if (phase == PH_LEN64 && hdr_cnt == 4'd8) begin
                        hdr_cnt = 4'd0;
                        if (remaining > {32'd0, max_long_len}) begin
                            stop_with(KIND_LONG);
                        end else begin
                            phase = PH_MASK;
                        end
                    end
                end
                PH_MASK: begin
                    mask_key = {mask_key[23:0], b};
                    hdr_cnt  = hdr_cnt + 4'd1;
                    if (hdr_cnt == 4'd4) begin
                        hdr_cnt  = 4'd0;
                        mask_pos = 2'd0;
                        if (opcode == OP_TEXT || opcode == OP_BINARY) begin
                            msg_open      = 1'b1;
                            msg_has_bytes = 1'b0;
                        end
                        if (remaining != 64'd0) begin
                            phase = PH_DATA;
                        end else begin
                            phase = PH_HEAD0;
                            // empty final frame closes the message, marker only if it had bytes
                            if (opcode < OP_FIRST_CONTROL && msg_open && fin) begin
                                if (msg_has_bytes) begin
                                    push_result(KIND_EMPTY, 8'h00, 1'b1);
                                end
                                msg_open      = 1'b0;
                                msg_has_bytes = 1'b0;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    plain      = b ^ mask_key[8 * (3 - int'(mask_pos)) +: 8];
                    remaining  = remaining - 64'd1;
                    mask_pos   = mask_pos + 2'd1;
                    frame_done = (remaining == 64'd0);
                    if (frame_done) begin
                        phase = PH_HEAD0;
                    end
                    // control, reserved and orphan continuation payload is dropped
                    if (opcode < OP_FIRST_CONTROL && msg_open) begin
                        msg_has_bytes = 1'b1;
                        if (frame_done && fin) begin
                            msg_open      = 1'b0;
                            msg_has_bytes = 1'b0;
                            push_result(KIND_BYTE, plain, 1'b1);
                        end else begin
                            push_result(KIND_BYTE, plain, 1'b0);
                        end
                    end
                end
                default: begin
                    opcode  = b[3:0];
                    fin     = b[7];
                    rsv     = b[6:4];
                    hdr_cnt = 4'd0;
                    phase   = PH_HEAD1;
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            max_long_len  = MAX_LONG_RESET;
            phase         = PH_HEAD0;
            hdr_cnt       = 4'd0;
            opcode        = OP_CONT;
            fin           = 1'b0;
            rsv           = 3'd0;
            short_len     = 7'd0;
            remaining     = 64'd0;
            mask_key      = 32'd0;
            mask_pos      = 2'd0;
            msg_open      = 1'b0;
            msg_has_bytes = 1'b0;
            stopped       = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                max_long_len = i_cfg_wr_data;
            end
            // output side first: a byte taken now cannot show up at this edge
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, ", $time,
                             "got kind %0d data %02h last %0b",
                             i_m_tuser, i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tuser !== want.kind || i_m_tdata !== want.data ||
                        i_m_tlast !== want.last) begin
                        $display("%0t: mismatch: ", $time,
                                 "expected kind %0d data %02h last %0b, ",
                                 want.kind, want.data, want.last,
                                 "got kind %0d data %02h last %0b",
                                 i_m_tuser, i_m_tdata, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_rx_byte(i_s_tdata);
            end
        end
        o_fail_count <= fails;
        o_pending    <= decoded_q.size();
    end

endmodule

[tb/tb_top.sv]
// testbench top for the websocket frame decoder: drives masked frame streams and
// configuration, stalls the output side, and gives the verdict
// depends on wsfd_pkg, websocket_frame_decoder and wsfd_result_checker
`timescale 1ns / 1ps

module tb_top;
    import wsfd_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         LONG_HOLD      = 150;
    localparam int         PHASE_BYTES    = 100;
    localparam int         PAYLOAD_BURST  = 40;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         IGNORED_BYTES  = 6;
    localparam logic [3:0] OP_PING        = 4'h9;
    localparam logic [3:0] OP_PONG        = 4'hA;
    localparam logic [3:0] OP_LAST_RSVD   = 4'hF;

    typedef enum int {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] payload_byte
    logic [2:0]  m_axis_tuser;            // [2:0] kind
    logic        m_axis_tlast;            // message_last

    int          fail_count;
    int          pending;
    int          bytes_sent    = 0;
    int          hold_requests = 0;
    bit          no_idle       = 1'b0;
    logic [31:0] cur_max       = MAX_LONG_RESET;

    websocket_frame_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    wsfd_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one byte item, with an occasional idle burst in front
    task automatic send_rx_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // one well-formed masked frame with random key and payload
    task automatic send_frame(input logic fin, input logic [3:0] op, input int unsigned len,
                              input t_len_form form);
        logic [31:0] key;
        logic [63:0] len64;
        key   = $urandom();
        len64 = 64'(len);
        send_rx_byte({fin, 3'b000, op});
        case (form)
            FORM_EXT16: begin
                send_rx_byte({1'b1, LEN_EXT16});
                send_rx_byte(len64[15:8]);
                send_rx_byte(len64[7:0]);
            end
            FORM_EXT64: begin
                send_rx_byte({1'b1, LEN_EXT64});
                for (int i = 7; i >= 0; i--) send_rx_byte(len64[8 * i +: 8]);
            end
            default: begin
                send_rx_byte({1'b1, len64[6:0]});
            end
        endcase
        for (int i = 3; i >= 0; i--) send_rx_byte(key[8 * i +: 8]);
        repeat (len) send_rx_byte(8'($urandom_range(0, 255)));
    endtask

    // drop valid and wait until every decoded result has come out
    task automatic wait_decoder_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_long_len(input logic [31:0] value);
        wait_decoder_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_max = value;
    endtask

    // random mix of data frames, control frames, reserved opcodes and orphan continuations
    task automatic send_random_frames(input int n_bytes, input bit with_hold);
        int          phase_start;
        int          r;
        int unsigned len;
        logic [3:0]  op;
        t_len_form   form;
        bit          hold_issued;
        phase_start = bytes_sent;
        hold_issued = 1'b0;
        while (bytes_sent - phase_start < n_bytes) begin
            // long receiver stall while a long message streams in
            if (with_hold && !hold_issued && bytes_sent - phase_start >= n_bytes / 2) begin
                hold_issued = 1'b1;
                hold_requests++;
                send_frame(1'b1, OP_TEXT, PAYLOAD_BURST, FORM_SHORT);
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                op = OP_CONT;
            end else if (r < 65) begin
                op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
            end else if (r < 82) begin
                op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
            end else begin
                op = 4'($urandom_range(OP_FIRST_CONTROL, OP_LAST_RSVD));
                if (op == OP_CLOSE) op = OP_FIRST_CONTROL;
            end
            r = $urandom_range(0, 99);
            if (r < 15) len = 0;
            else if (r < 85) len = $urandom_range(1, 12);
            else if (r < 97) len = $urandom_range(13, 125);
            else len = $urandom_range(126, 300);
            r = $urandom_range(0, 99);
            if (r >= 80 && len <= cur_max) form = FORM_EXT64;
            else if (r >= 60 || len > 125) form = FORM_EXT16;
            else form = FORM_SHORT;
            send_frame(1'($urandom_range(0, 1)), op, len, form);
        end
    endtask

    // output side: random stall bursts plus the requested long holds
    initial begin
        int stall_left;
        int hold_left;
        int holds_done;
        bit ready;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (holds_done < hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                ready     = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready = 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                ready      = 1'b0;
            end else begin
                ready = 1'b1;
            end
            m_axis_tready <= ready;
        end
    end

    // watchdog on cycles without any accepted item
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial begin
        t_kind       stop_kind;
        logic [3:0]  op;
        logic [63:0] too_long;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-byte message, then a plain one-frame message
        send_frame(1'b1, OP_TEXT, 0, FORM_SHORT);
        send_frame(1'b1, OP_TEXT, 3, FORM_SHORT);
        // fragmented message with a ping in between, closed by an empty final frame
        send_frame(1'b0, OP_BINARY, 2, FORM_EXT16);
        send_frame(1'b0, OP_CONT, 0, FORM_SHORT);
        send_frame(1'b1, OP_PING, 2, FORM_SHORT);
        send_frame(1'b0, OP_CONT, 1, FORM_EXT64);
        send_frame(1'b1, OP_CONT, 0, FORM_SHORT);
        // continuation with no open message
        send_frame(1'b1, OP_CONT, 2, FORM_SHORT);
        // new message while one is open
        send_frame(1'b0, OP_TEXT, 1, FORM_SHORT);
        send_frame(1'b1, OP_BINARY, 1, FORM_SHORT);
        // reserved opcodes at both ends of the range
        send_frame(1'b1, OP_FIRST_CONTROL, 0, FORM_SHORT);
        send_frame(1'b1, OP_LAST_RSVD, 1, FORM_SHORT);
        // fragmented message that never carries a byte
        send_frame(1'b0, OP_TEXT, 0, FORM_SHORT);
        send_frame(1'b1, OP_CONT, 0, FORM_EXT16);

        // random phases under different length limits
        set_max_long_len(32'd0);
        send_random_frames(PHASE_BYTES, 1'b0);
        set_max_long_len(32'hFFFF_FFFF);
        send_random_frames(PHASE_BYTES, 1'b1);
        set_max_long_len(32'($urandom_range(1, 40)));
        send_random_frames(PHASE_BYTES, 1'b1);
        set_max_long_len(MAX_LONG_RESET);
        no_idle = 1'b1;
        send_random_frames(PHASE_BYTES, 1'b0);

        // one terminating frame, then bytes the halted decoder must drop
        stop_kind = t_kind'($urandom_range(KIND_CLOSE, KIND_LONG));
        op = 4'($urandom_range(0, 15));
        if (op == OP_CLOSE) op = OP_TEXT;
        case (stop_kind)
            KIND_CLOSE: begin
                send_rx_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), OP_CLOSE});
                send_rx_byte(8'($urandom_range(0, 255)));
            end
            KIND_RSV: begin
                send_rx_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), op});
                send_rx_byte({1'b1, 7'($urandom_range(0, 125))});
            end
            KIND_NOMASK: begin
                send_rx_byte({1'($urandom_range(0, 1)), 3'b000, op});
                send_rx_byte({1'b0, 7'($urandom_range(0, 127))});
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    too_long = {32'($urandom()), 32'($urandom())} | 64'h1_0000_0000;
                end else begin
                    too_long = 64'(cur_max) + 64'($urandom_range(1, 1000));
                end
                send_rx_byte({1'($urandom_range(0, 1)), 3'b000, op});
                send_rx_byte({1'b1, LEN_EXT64});
                for (int i = 7; i >= 0; i--) send_rx_byte(too_long[8 * i +: 8]);
            end
        endcase
        repeat (IGNORED_BYTES) send_rx_byte(8'($urandom_range(0, 255)));

        wait_decoder_idle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[websocket_frame_decoder.f]
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_front.sv
rtl/wsfd_queue.sv
rtl/wsfd_back.sv
rtl/websocket_frame_decoder.sv
tb/wsfd_result_checker.sv
tb/tb_top.sv
